@@ hw/rtl/crc8e_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc8e_pkg
// Shared constants, the burst record and the CRC-8 byte update for the
// framed packet encoder.
// ----------------------------------------------------------------------------
package crc8e_pkg;

	localparam int BURST_MAX = 7;                    // most bytes one request causes
	localparam int CNT_W     = $clog2(BURST_MAX + 1);

	localparam logic [7:0] MAGIC_FIRST  = 8'hA5;
	localparam logic [7:0] MAGIC_SECOND = 8'h53;
	localparam logic [7:0] CRC_POLY     = 8'h07;

	localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(6);  // header plus one more byte
	localparam logic [CNT_W-1:0] ONE_BYTE  = CNT_W'(1);

	// Bytes that one accepted request puts on the output stream, lowest first.
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		logic                      has_crc;   // last byte is the frame CRC
	} burst_t;

	// CRC-8, polynomial 0x07, MSB first, one byte.
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/crc8e_framer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc8e_framer
// Input register plus frame state; builds the byte burst for each request.
// ----------------------------------------------------------------------------
module crc8e_framer
	import crc8e_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] frame_type,
	input  wire logic [7:0] payload_len,
	input  wire logic [7:0] seq_skip,
	input  wire logic [7:0] data_byte,
	output logic            burst_valid,
	input  wire logic       burst_ready,
	output burst_t          burst
);

	logic       vld_s1;
	logic [1:0] type_s1;
	logic [7:0] plen_s1;
	logic [7:0] skip_s1;
	logic [7:0] data_s1;

	logic [7:0] seq_q;
	logic [7:0] crc_q;
	logic [7:0] left_q;

	logic       adv;
	logic       hdr;
	logic       zero_len;
	logic       frame_done;
	logic [7:0] seq_use;
	logic [7:0] c_type;
	logic [7:0] c_seq;
	logic [7:0] c_hdr;
	logic [7:0] c_data;
	logic [7:0] left_eff;
	logic [7:0] left_nx;

	assign adv         = vld_s1 && burst_ready;
	assign in_ready    = !vld_s1 || burst_ready;
	assign burst_valid = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			type_s1 <= frame_type;
			plen_s1 <= payload_len;
			skip_s1 <= seq_skip;
			data_s1 <= data_byte;
		end
	end

	always_comb begin
		hdr      = (left_q == 8'd0);
		zero_len = hdr && (plen_s1 == 8'd0);
		seq_use  = seq_q + skip_s1;
		c_type   = crc8_feed(8'h00, {6'b0, type_s1});
		c_seq    = crc8_feed(c_type, seq_use);
		c_hdr    = crc8_feed(c_seq, plen_s1);
		c_data   = crc8_feed(hdr ? c_hdr : crc_q, data_s1);
		left_eff = hdr ? plen_s1 : left_q;
		left_nx  = left_eff - 8'd1;
		frame_done = zero_len || (left_nx == 8'd0);

		burst = '0;
		if (hdr) begin
			burst.bytes[0] = MAGIC_FIRST;
			burst.bytes[1] = MAGIC_SECOND;
			burst.bytes[2] = {6'b0, type_s1};
			burst.bytes[3] = seq_use;
			burst.bytes[4] = plen_s1;
			burst.bytes[5] = zero_len ? c_hdr : data_s1;
			burst.bytes[6] = c_data;
			burst.cnt      = (zero_len || !frame_done) ? HDR_BYTES : HDR_BYTES + ONE_BYTE;
		end else begin
			burst.bytes[0] = data_s1;
			burst.bytes[1] = c_data;
			burst.cnt      = frame_done ? ONE_BYTE + ONE_BYTE : ONE_BYTE;
		end
		burst.has_crc = frame_done;
	end

	// Advance frame state when the burst moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= 8'd0;
			crc_q  <= 8'd0;
			left_q <= 8'd0;
		end else if (adv) begin
			if (hdr) begin
				seq_q <= seq_use + 8'd1;
			end
			crc_q  <= frame_done ? 8'd0 : c_data;
			left_q <= zero_len ? 8'd0 : left_nx;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/crc8e_serializer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc8e_serializer
// Result register: holds one burst and shifts it out a byte per transfer.
// ----------------------------------------------------------------------------
module crc8e_serializer
	import crc8e_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       burst_valid,
	output logic            burst_ready,
	input  wire burst_t     burst,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            crc_mark,
	output logic            run_last
);

	logic [BURST_MAX-1:0][7:0] bytes_s2;
	logic [CNT_W-1:0]          cnt_s2;
	logic                      crc_s2;
	logic                      take;

	assign out_valid   = (cnt_s2 != '0);
	assign run_last    = (cnt_s2 == ONE_BYTE);
	assign out_byte    = bytes_s2[0];
	assign crc_mark    = crc_s2 && run_last;
	assign take        = out_valid && out_ready;
	assign burst_ready = !out_valid || (take && run_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (burst_ready && burst_valid) begin
			cnt_s2 <= burst.cnt;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - ONE_BYTE;
		end
	end

	always_ff @(posedge clk) begin
		if (burst_ready && burst_valid) begin
			bytes_s2 <= burst.bytes;
			crc_s2   <= burst.has_crc;
		end else if (take) begin
			bytes_s2 <= {8'h00, bytes_s2[BURST_MAX-1:1]};
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/crc8_framed_packet_encoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_framed_packet_encoder_unit
// Wraps payload bytes into CRC-8 protected frames and streams them as bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one payload byte per request. The first byte of a frame
//   also carries the frame type, payload length and sequence skip; these are
//   ignored on later bytes. Master channel m_*: one framed byte per transfer.
//   A frame opens with A5 53, type, sequence, length; the CRC-8 (poly 0x07,
//   init 0) over type..payload closes it, flagged on m_tuser. m_tlast marks
//   the last output byte caused by one request.
// Path: an accepted request is held in the input register, and its burst is
//   loaded into the result register once that is free; its first output byte
//   is then valid. The next request can wait in the input register meanwhile.
// Output: one output byte per cycle while m_tready is high, set by the result
//   register draining a byte at a time. A mid-frame payload byte yields 1 byte,
//   the final byte of a frame 2, the first byte of a frame 6 or 7 (7 only for a one byte frame).
// Reset: clears the sequence number, CRC and remaining count; the block
//   starts between frames with both channels empty.
// Stall: while m_tready is low the result register holds its byte; the input
//   register fills and s_tready then drops until the burst drains.
// ----------------------------------------------------------------------------
module crc8_framed_packet_encoder_unit
	import crc8e_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // [7:0] payload_len, [15:8] seq_skip, [23:16] data_byte
	input  wire logic [1:0]  s_tuser,  // [1:0] frame_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [7:0] out_byte
	output logic [0:0]       m_tuser,  // [0] crc_mark
	output logic             m_tlast   // run_last
);

	logic   burst_valid;
	logic   burst_ready;
	burst_t burst;

	// Register the request and build its byte burst from the frame state.
	crc8e_framer u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.frame_type  (s_tuser),
		.payload_len (s_tdata[7:0]),
		.seq_skip    (s_tdata[15:8]),
		.data_byte   (s_tdata[23:16]),
		.burst_valid (burst_valid),
		.burst_ready (burst_ready),
		.burst       (burst)
	);

	// Hold the burst and hand it out one byte per transfer.
	crc8e_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (burst_valid),
		.burst_ready (burst_ready),
		.burst       (burst),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.crc_mark    (m_tuser[0]),
		.run_last    (m_tlast)
	);

`ifndef SYNTH
	// The CRC byte always closes the request's burst.
	a_crc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("frame CRC byte not marked last");

	// Input backpressure only arises while a result is pending.
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending output");

	// A taken non-last byte is followed by another byte of the same burst.
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("burst ended without last byte");
`endif

endmodule
`default_nettype wire

@@ tb/sv/crc8_framed_packet_encoder_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_packet_encoder_unit_test
// Streams payload byte requests into the framed packet encoder and checks
// every framed output byte against a cycle-free model of the framing: header
// (A5 53 type seq len), payload, CRC-8 trailer, CRC flag and per-request
// tlast. Runs three flow-control phases plus one long output back-pressure.
// ----------------------------------------------------------------------------
module crc8_framed_packet_encoder_unit_test;
	import crc8e_pkg::*;

	// Frame type codes; zero is out of range but must pass through untouched.
	localparam logic [1:0] FT_INVALID = 2'd0;
	localparam logic [1:0] FT_SCHEMA  = 2'd1;
	localparam logic [1:0] FT_DATA    = 2'd2;
	localparam logic [1:0] FT_ROWS    = 2'd3;

	localparam int HOLD_CYCLES   = 120;   // long output hold-off
	localparam int STALL_LIMIT   = 4000;  // cycles without any transfer
	localparam int DRAIN_CYCLES  = 12;    // settle time after the last drain
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [1:0] frame_type;
		logic [7:0] payload_len;
		logic [7:0] seq_skip;
		logic [7:0] data_byte;
	} payload_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       crc_mark;
		logic       run_last;
	} framed_byte_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // [7:0] payload_len, [15:8] seq_skip, [23:16] data_byte
	logic [1:0]  s_tuser  = '0;  // [1:0] frame_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [7:0] out_byte
	logic [0:0]  m_tuser;        // [0] crc_mark
	logic        m_tlast;        // run_last

	crc8_framed_packet_encoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Requests waiting to be driven, and framed bytes owed by the block.
	payload_req_t payload_reqs[$];
	framed_byte_t framed_bytes_due[$];
	payload_req_t launch_req;

	// Flow control knobs, written by the sequencer at rising edges only.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req    = 0;

	// Model state of the encoder.
	logic [7:0] next_seq;
	logic [7:0] run_crc;
	logic [7:0] frame_left;

	logic in_taken;
	int   hold_seen;
	int   stall_left;
	int   idle_cycles;
	int   mismatches    = 0;
	int   reqs_queued   = 0;
	int   reqs_taken    = 0;
	int   bytes_checked = 0;
	int   frames_opened = 0;
	int   empty_frames  = 0;

	// CRC-8, polynomial 0x07, MSB first: fold in one byte.
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] acc;
		logic       fb;
		acc = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			fb  = acc[7];
			acc = acc << 1;
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	task automatic owe_byte(input logic [7:0] value, input logic is_end);
		framed_byte_t fb;
		fb.out_byte  = value;
		fb.crc_mark  = is_end;
		fb.run_last  = 1'b0;
		framed_bytes_due.push_back(fb);
	endtask

	// Work out the framed bytes one accepted request causes.
	task automatic encode_request(input payload_req_t r);
		logic [7:0] seq;
		logic       empty;
		empty = 1'b0;
		if (frame_left == 8'd0) begin
			// the sum is 8 bits wide, so the sequence number wraps past 255
			seq      = next_seq + r.seq_skip;
			next_seq = seq + 8'd1;
			frames_opened++;
			owe_byte(MAGIC_FIRST, 1'b0);
			owe_byte(MAGIC_SECOND, 1'b0);
			owe_byte({6'd0, r.frame_type}, 1'b0);
			owe_byte(seq, 1'b0);
			owe_byte(r.payload_len, 1'b0);
			run_crc = crc8_next(8'h00, {6'd0, r.frame_type});
			run_crc = crc8_next(run_crc, seq);
			run_crc = crc8_next(run_crc, r.payload_len);
			if (r.payload_len == 8'd0) begin
				// empty frame: close at once and drop this data byte
				owe_byte(run_crc, 1'b1);
				run_crc = 8'h00;
				empty   = 1'b1;
				empty_frames++;
			end else begin
				frame_left = r.payload_len;
			end
		end
		if (!empty) begin
			owe_byte(r.data_byte, 1'b0);
			run_crc    = crc8_next(run_crc, r.data_byte);
			frame_left = frame_left - 8'd1;
			if (frame_left == 8'd0) begin
				owe_byte(run_crc, 1'b1);
				run_crc = 8'h00;
			end
		end
		framed_bytes_due[framed_bytes_due.size() - 1].run_last = 1'b1;
	endtask

	task automatic push_req(input logic [1:0] ftype, input logic [7:0] len,
	                        input logic [7:0] skip, input logic [7:0] data);
		payload_req_t r;
		r.frame_type  = ftype;
		r.payload_len = len;
		r.seq_skip    = skip;
		r.data_byte   = data;
		payload_reqs.push_back(r);
		reqs_queued++;
	endtask

	// One frame: header fields on the first request, noise on the rest.
	task automatic add_frame(input logic [1:0] ftype, input logic [7:0] len,
	                         input logic [7:0] skip);
		push_req(ftype, len, skip, 8'($urandom_range(255)));
		for (int k = 1; k < len; k++) begin
			push_req(2'($urandom_range(3)), 8'($urandom_range(255)),
			         8'($urandom_range(255)), 8'($urandom_range(255)));
		end
	endtask

	task automatic add_random_frame();
		int         pick;
		logic [7:0] len;
		logic [7:0] skip;
		pick = $urandom_range(99);
		if (pick < 10) begin
			len = 8'd0;
		end else begin
			len = 8'($urandom_range(12, 1));
		end
		pick = $urandom_range(99);
		if (pick < 15) begin
			skip = 8'hFF;
		end else if (pick < 35) begin
			skip = 8'h00;
		end else begin
			skip = 8'($urandom_range(255));
		end
		add_frame(2'($urandom_range(3)), len, skip);
	endtask

	// Wait at falling edges until every request is taken and every byte seen.
	task automatic wait_drained();
		@(negedge clk);
		while (payload_reqs.size() != 0 || framed_bytes_due.size() != 0 || s_tvalid) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Driver: advance to the next request only once the current one is taken.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (payload_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				launch_req = payload_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {launch_req.data_byte, launch_req.seq_skip,
				             launch_req.payload_len};
				s_tuser  <= launch_req.frame_type;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
			hold_seen  <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen  <= hold_req;
			stall_left <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Monitor: predict on accepted requests, check accepted bytes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken   <= 1'b0;
			next_seq   = 8'h00;
			run_crc    = 8'h00;
			frame_left = 8'h00;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				bytes_checked++;
				if (framed_bytes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("[%0t] unexpected byte %02h end=%0b last=%0b", $realtime,
						         m_tdata, m_tuser[0], m_tlast);
					end
				end else if (m_tdata !== framed_bytes_due[0].out_byte
				             || m_tuser[0] !== framed_bytes_due[0].crc_mark
				             || m_tlast !== framed_bytes_due[0].run_last) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("[%0t] byte %0d: expected %02h end=%0b last=%0b, got %02h end=%0b last=%0b",
						         $realtime, bytes_checked, framed_bytes_due[0].out_byte,
						         framed_bytes_due[0].crc_mark, framed_bytes_due[0].run_last,
						         m_tdata, m_tuser[0], m_tlast);
					end
					void'(framed_bytes_due.pop_front());
				end else begin
					void'(framed_bytes_due.pop_front());
				end
			end
			if (s_tvalid && s_tready) begin
				reqs_taken++;
				encode_request({s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]});
			end
		end
	end

	// Watchdog: count cycles with work pending but no transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (payload_reqs.size() != 0 || framed_bytes_due.size() != 0 || s_tvalid) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] no progress for %0d cycles, %0d requests and %0d bytes outstanding",
				         $realtime, idle_cycles, payload_reqs.size(), framed_bytes_due.size());
				$display("crc8_framed_packet_encoder_unit_test NOT OK");
				$finish;
			end
		end
	end

	// Sequencer: fill the request queue phase by phase.
	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: light sender gaps, heavy output back-pressure.
		tx_idle_pct = 11;
		rx_idle_pct = 87;
		push_req(FT_SCHEMA, 8'd1, 8'h00, 8'h00);   // shortest non-empty frame, data zero
		push_req(FT_INVALID, 8'd0, 8'h00, 8'hFF);  // type zero, empty frame
		push_req(FT_ROWS, 8'd2, 8'hFF, 8'hFF);     // max skip wraps the sequence
		push_req(FT_INVALID, 8'hFF, 8'hFF, 8'h00); // mid-frame: header fields ignored
		push_req(FT_DATA, 8'd0, 8'hFF, 8'h5A);     // empty frame after a wrap
		add_frame(FT_DATA, 8'd3, 8'h55);
		add_frame(FT_INVALID, 8'd4, 8'hAA);
		add_frame(FT_ROWS, 8'd0, 8'h01);
		add_frame(FT_SCHEMA, 8'd5, 8'h80);
		while (reqs_queued < 90) begin
			add_random_frame();
		end
		wait_drained();

		// Phase two: heavy sender gaps, light back-pressure.
		tx_idle_pct = 87;
		rx_idle_pct = 11;
		while (reqs_queued < 150) begin
			add_random_frame();
		end
		wait_drained();

		// Phase three: full rate, one long frame, and a long
		// output hold-off while the sender keeps pushing.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		add_frame(FT_DATA, 8'd64, 8'h7F);
		while (reqs_queued < 280) begin
			add_random_frame();
		end
		hold_req = hold_req + 1;
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d frames (%0d empty), %0d framed bytes checked",
		         reqs_taken, frames_opened, empty_frames, bytes_checked);
		$display("phases: output-starved, input-starved, full rate with a %0d-cycle hold-off",
		         HOLD_CYCLES);
		if (mismatches == 0 && framed_bytes_due.size() == 0) begin
			$display("crc8_framed_packet_encoder_unit_test OK");
		end else begin
			$display("%0d mismatches, %0d bytes still owed", mismatches, framed_bytes_due.size());
			$display("crc8_framed_packet_encoder_unit_test NOT OK");
		end
		$finish;
	end

endmodule
